@@ design/gnmc_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gnmc_pkg: shared types and constants for the grid neighbor mine counter
// Request/result payloads, control structs between the counter blocks,
// register indexes and field widths.
// ---------------------------------------------------------------------------
package gnmc_pkg;

   localparam int COL_W      = 8;
   localparam int ROW_W      = 10;
   localparam int CODE_W     = 4;
   localparam int PEND_W     = COL_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [CODE_W-1:0] MINE_CODE = 4'd9;

   localparam logic MODE_CELL  = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS    = 2'd1;

   typedef struct packed {
      logic mode;
      logic is_mine;
   } gnmc_req_type;

   typedef struct packed {
      logic [CODE_W-1:0] cell_code;
      logic              row_end;
      logic              frame_end;
   } gnmc_rsp_type;

   // Position flags of the cell whose result is being produced
   typedef struct packed {
      logic top_ok;
      logic bot_ok;
      logic left_ok;
      logic right_ok;
      logic row_end;
      logic frame_end;
      logic lag;
   } gnmc_pos_type;

   // What the current request does to the window and the result path
   typedef struct packed {
      logic         shift;
      logic         bit_in;
      logic         emit;
      gnmc_pos_type pos;
   } gnmc_step_type;

   // 3x3 neighborhood taps; x = newest row, y = middle, z = oldest
   typedef struct packed {
      logic x0;
      logic x1;
      logic x2;
      logic y0;
      logic y1;
      logic y2;
      logic z0;
      logic z1;
      logic z2;
   } gnmc_taps_type;

endpackage

@@ design/gnmc_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gnmc_ram: generic RAM, one write port, two registered read ports
// Read-first: a read of the address written in the same cycle returns the
// old contents.
// ---------------------------------------------------------------------------
module gnmc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 258
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

endmodule

@@ design/gnmc_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gnmc_ctrl: frame counters and configuration registers
// Tracks input/output positions and the number of pending cells, decides
// per request whether the window shifts and whether a result is produced.
// ---------------------------------------------------------------------------
module gnmc_ctrl #(
   parameter int MAX_COLUMNS = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_fire,
   input  gnmc_pkg::gnmc_req_type              req_data,
   input  logic                                csr_we,
   input  logic [gnmc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gnmc_pkg::CSR_DATA_W-1:0]     csr_data,
   output gnmc_pkg::gnmc_step_type             step,
   output logic [gnmc_pkg::COL_W-1:0]          cols,
   output logic                                lag
);

   localparam int COLS_RST_INT = (MAX_COLUMNS < 128) ? MAX_COLUMNS : 128;
   localparam logic [gnmc_pkg::COL_W-1:0] COLS_RST = gnmc_pkg::COL_W'(COLS_RST_INT);

   logic [gnmc_pkg::COL_W-1:0]  cols_ff, cols_in;
   logic [gnmc_pkg::ROW_W-1:0]  rows_ff, rows_in;
   logic [gnmc_pkg::COL_W-1:0]  in_col_ff, in_col_in;
   logic [gnmc_pkg::ROW_W-1:0]  in_row_ff, in_row_in;
   logic                        in_done_ff, in_done_in;
   logic [gnmc_pkg::COL_W-1:0]  out_col_ff, out_col_in;
   logic [gnmc_pkg::ROW_W-1:0]  out_row_ff, out_row_in;
   logic [gnmc_pkg::PEND_W-1:0] pend_ff, pend_in;

   logic                        is_cell, cell_ok, flush_ok, pend_full;
   logic                        in_col_last, in_row_last, out_col_last, out_row_last;
   logic [gnmc_pkg::COL_W-1:0]  csr_cols;
   logic [gnmc_pkg::ROW_W-1:0]  csr_rows;

   assign cols = cols_ff;
   assign lag  = (rows_ff == gnmc_pkg::ROW_W'(1));

   always_comb begin
      is_cell      = (req_data.mode == gnmc_pkg::MODE_CELL);
      cell_ok      = is_cell && !in_done_ff;
      flush_ok     = !is_cell && in_done_ff && (pend_ff != '0);
      pend_full    = (pend_ff == gnmc_pkg::PEND_W'(cols_ff) + gnmc_pkg::PEND_W'(1));
      in_col_last  = (in_col_ff == cols_ff - gnmc_pkg::COL_W'(1));
      in_row_last  = (in_row_ff == rows_ff - gnmc_pkg::ROW_W'(1));
      out_col_last = (out_col_ff == cols_ff - gnmc_pkg::COL_W'(1));
      out_row_last = (out_row_ff == rows_ff - gnmc_pkg::ROW_W'(1));

      step.shift            = cell_ok || flush_ok;
      step.bit_in           = cell_ok && req_data.is_mine;
      step.emit             = (cell_ok && pend_full) || flush_ok;
      step.pos.top_ok       = (out_row_ff != '0);
      step.pos.bot_ok       = !out_row_last;
      step.pos.left_ok      = (out_col_ff != '0);
      step.pos.right_ok     = !out_col_last;
      step.pos.row_end      = out_col_last;
      step.pos.frame_end    = out_col_last && out_row_last;
      step.pos.lag          = lag;

      // Clamp register writes to the usable range
      csr_cols = csr_data[gnmc_pkg::COL_W-1:0];
      if (csr_cols == '0) begin
         csr_cols = gnmc_pkg::COL_W'(1);
      end else if (32'(csr_data[gnmc_pkg::COL_W-1:0]) > MAX_COLUMNS) begin
         csr_cols = gnmc_pkg::COL_W'(MAX_COLUMNS);
      end
      csr_rows = csr_data[gnmc_pkg::ROW_W-1:0];
      if (csr_rows == '0) begin
         csr_rows = gnmc_pkg::ROW_W'(1);
      end
   end

   always_comb begin
      cols_in    = cols_ff;
      rows_in    = rows_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      in_done_in = in_done_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      pend_in    = pend_ff;

      if (csr_we) begin
         unique case (csr_index)
            gnmc_pkg::CSR_COLUMNS: cols_in = csr_cols;
            gnmc_pkg::CSR_ROWS:    rows_in = csr_rows;
            default: ;
         endcase
         // a write to either register restarts the frame; other indexes do nothing
         if (csr_index == gnmc_pkg::CSR_COLUMNS || csr_index == gnmc_pkg::CSR_ROWS) begin
            in_col_in  = '0;
            in_row_in  = '0;
            in_done_in = 1'b0;
            out_col_in = '0;
            out_row_in = '0;
            pend_in    = '0;
         end
      end else if (req_fire) begin
         if (cell_ok) begin
            if (in_col_last) begin
               in_col_in = '0;
               if (in_row_last) begin
                  in_row_in  = '0;
                  in_done_in = 1'b1;
               end else begin
                  in_row_in = in_row_ff + gnmc_pkg::ROW_W'(1);
               end
            end else begin
               in_col_in = in_col_ff + gnmc_pkg::COL_W'(1);
            end
            if (!pend_full) begin
               pend_in = pend_ff + gnmc_pkg::PEND_W'(1);
            end
         end
         if (flush_ok) begin
            pend_in = pend_ff - gnmc_pkg::PEND_W'(1);
         end
         if (step.emit) begin
            if (step.pos.frame_end) begin
               in_col_in  = '0;
               in_row_in  = '0;
               in_done_in = 1'b0;
               out_col_in = '0;
               out_row_in = '0;
               pend_in    = '0;
            end else if (out_col_last) begin
               out_col_in = '0;
               out_row_in = out_row_ff + gnmc_pkg::ROW_W'(1);
            end else begin
               out_col_in = out_col_ff + gnmc_pkg::COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff    <= COLS_RST;
         rows_ff    <= gnmc_pkg::ROW_W'(1);
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         in_done_ff <= 1'b0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         pend_ff    <= '0;
      end else begin
         cols_ff    <= cols_in;
         rows_ff    <= rows_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         in_done_ff <= in_done_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         pend_ff    <= pend_in;
      end
   end

endmodule

@@ design/gnmc_window.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gnmc_window: line history and 3x3 neighborhood taps
// Mine flags go into a ring RAM; two reads one and two rows back feed short
// shift chains that form the window around the cell being reported.
// ---------------------------------------------------------------------------
module gnmc_window #(
   parameter int MAX_COLUMNS = 128
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift,
   input  logic                        bit_in,
   input  logic [gnmc_pkg::COL_W-1:0]  cols,
   input  logic                        lag,
   output gnmc_pkg::gnmc_taps_type     taps
);

   localparam int DEPTH = 2 * MAX_COLUMNS + 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = AW + 1;

   logic [AW-1:0] wptr_ff, wptr_in;
   logic [SW-1:0] cols_s, off_a, off_b, sum_a, sum_b;
   logic [AW-1:0] addr_a, addr_b;
   logic          rd_a, rd_b;
   logic          x0_ff, x1_ff, x2_ff, y1_ff, y2_ff, z1_ff, z2_ff;

   always_comb begin
      wptr_in = wptr_ff;
      if (shift) begin
         wptr_in = (wptr_ff == AW'(DEPTH - 1)) ? '0 : wptr_ff + AW'(1);
      end
      // cols never exceeds MAX_COLUMNS, so offsets stay below DEPTH
      cols_s = SW'(cols);
      off_a  = cols_s;
      // single-row frames read the cell right of center instead of two rows back
      off_b  = lag ? cols_s - SW'(1) : cols_s + cols_s;
      sum_a  = {1'b0, wptr_ff} + SW'(DEPTH) - off_a;
      sum_b  = {1'b0, wptr_ff} + SW'(DEPTH) - off_b;
      if (sum_a >= SW'(DEPTH)) begin
         sum_a = sum_a - SW'(DEPTH);
      end
      if (sum_b >= SW'(DEPTH)) begin
         sum_b = sum_b - SW'(DEPTH);
      end
      addr_a = sum_a[AW-1:0];
      addr_b = sum_b[AW-1:0];
   end

   gnmc_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_hist (
      .clock     (clock),
      .wr_en     (shift),
      .wr_addr   (wptr_ff),
      .wr_data   (bit_in),
      .rd_en     (shift),
      .rd_addr_a (addr_a),
      .rd_addr_b (addr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         x0_ff <= bit_in;
         x1_ff <= x0_ff;
         x2_ff <= x1_ff;
         y1_ff <= rd_a;
         y2_ff <= y1_ff;
         z1_ff <= rd_b;
         z2_ff <= z1_ff;
      end
   end

   assign taps.x0 = x0_ff;
   assign taps.x1 = x1_ff;
   assign taps.x2 = x2_ff;
   assign taps.y0 = rd_a;
   assign taps.y1 = y1_ff;
   assign taps.y2 = y2_ff;
   assign taps.z0 = rd_b;
   assign taps.z1 = z1_ff;
   assign taps.z2 = z2_ff;

endmodule

@@ design/grid_neighbor_mine_count.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_neighbor_mine_count: streaming minesweeper adjacent-mine counter
// Cells arrive in raster order; each result is 9 for a mine, else the count
// of mines among the in-grid neighbors, tagged with row and frame end.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one cell (mode 0) or flush tick (mode 1) per request.
//   rsp_*  : one result per producing request, in raster order.
//   csr_*  : index 0 = columns, index 1 = rows; taken only while idle and no
//            request is offered. Writing either register restarts the frame
//            (line history kept); other indexes change nothing.
// A cell's result is produced by the request columns+1 cells later; once the
// whole frame is in, each flush request drains one pending result.
// Pipeline: the accepting edge loads the window stage, and the result
// register loads from it as soon as that register is free.
// Throughput: one request per cycle unless rsp stalls; the history RAM is
// written and read once per window shift; the count is a single adder tree.
// Reset: counters cleared, columns = 128 (capped at MAX_COLUMNS), rows = 1.
// The history RAM is not cleared; reads outside the grid are masked.
// When rsp is stalled the result register holds, one more producing request
// may enter the window stage, and after that req_stall is raised.
// ---------------------------------------------------------------------------
module grid_neighbor_mine_count #(
   parameter int MAX_COLUMNS = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  gnmc_pkg::gnmc_req_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output gnmc_pkg::gnmc_rsp_type              rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gnmc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [gnmc_pkg::CSR_DATA_W-1:0]     csr_data
);

   gnmc_pkg::gnmc_step_type  step;
   gnmc_pkg::gnmc_taps_type  taps;
   gnmc_pkg::gnmc_pos_type   s1_pos_ff;
   gnmc_pkg::gnmc_rsp_type   rsp_data_ff, rsp_data_in;
   logic [gnmc_pkg::COL_W-1:0] cols;
   logic                     lag;
   logic                     s1_valid_ff, s1_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     s2_load, req_fire, csr_we;
   logic                     center, left_b, right_b;
   logic [gnmc_pkg::CODE_W-1:0] count;

   // Result register frees up when empty or being taken this cycle
   assign s2_load   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s2_load;
   assign req_fire  = req_valid && !req_stall;
   // a register write never shares an edge with a request
   assign csr_ready = !s1_valid_ff && !rsp_valid_ff && !req_valid;
   assign csr_we    = csr_valid && csr_ready;

   gnmc_ctrl #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .step      (step),
      .cols      (cols),
      .lag       (lag)
   );

   gnmc_window #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_window (
      .clock  (clock),
      .reset  (reset),
      .shift  (req_fire && step.shift),
      .bit_in (step.bit_in),
      .cols   (cols),
      .lag    (lag),
      .taps   (taps)
   );

   // Window stage: taps hold the neighborhood of the cell in s1_pos_ff.
   // Normally the newest tap is the lower-right neighbor, so the center row
   // sits one tap back. Single-row frames drain one step earlier, leaving
   // the center on the newest middle tap and the right neighbor on z0.
   always_comb begin
      center  = s1_pos_ff.lag ? taps.y0 : taps.y1;
      left_b  = s1_pos_ff.lag ? taps.y1 : taps.y2;
      right_b = s1_pos_ff.lag ? taps.z0 : taps.y0;

      count = gnmc_pkg::CODE_W'(taps.z2 & s1_pos_ff.top_ok & s1_pos_ff.left_ok)
            + gnmc_pkg::CODE_W'(taps.z1 & s1_pos_ff.top_ok)
            + gnmc_pkg::CODE_W'(taps.z0 & s1_pos_ff.top_ok & s1_pos_ff.right_ok)
            + gnmc_pkg::CODE_W'(left_b & s1_pos_ff.left_ok)
            + gnmc_pkg::CODE_W'(right_b & s1_pos_ff.right_ok)
            + gnmc_pkg::CODE_W'(taps.x2 & s1_pos_ff.bot_ok & s1_pos_ff.left_ok)
            + gnmc_pkg::CODE_W'(taps.x1 & s1_pos_ff.bot_ok)
            + gnmc_pkg::CODE_W'(taps.x0 & s1_pos_ff.bot_ok & s1_pos_ff.right_ok);

      rsp_data_in.cell_code = center ? gnmc_pkg::MINE_CODE : count;
      rsp_data_in.row_end   = s1_pos_ff.row_end;
      rsp_data_in.frame_end = s1_pos_ff.frame_end;

      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = step.emit;
      end else if (s2_load) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s2_load) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pos_ff <= step.pos;
      end
      if (s2_load && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ design/gnmc_check.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gnmc_check: port-level checks for the grid neighbor mine counter
// Watches handshakes and result timing at the top-level ports; bound in.
// ---------------------------------------------------------------------------
module gnmc_check (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input gnmc_pkg::gnmc_rsp_type     rsp_data,
   input logic                       csr_valid,
   input logic                       csr_ready
);

   // stalled result holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   // requests back up only behind a stalled result
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without output backpressure");

   // a new result follows an accepted request through the window stage
   a_rsp_origin : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching request");

   // register writes are taken only with the result path empty
   a_csr_idle : assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |-> !rsp_valid)
      else $error("register write while a result is pending");

endmodule

bind grid_neighbor_mine_count gnmc_check u_gnmc_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the grid neighbor mine counter
// Streams grid frames in raster order through the request channel and
// reprograms the frame size between phases. A scoreboard predicts every
// result from its own copy of the line history and compares it field by
// field with what the result channel delivers.
// ---------------------------------------------------------------------------

localparam int GRID_MAX_COLS = 128;

class mine_count_board;
   localparam int HIST_DEPTH = 2 * GRID_MAX_COLS + 2;

   bit                         hist [HIST_DEPTH];
   int unsigned                in_row, in_col, out_row, out_col;
   logic [gnmc_pkg::COL_W-1:0] cols_reg;
   logic [gnmc_pkg::ROW_W-1:0] rows_reg;
   gnmc_pkg::gnmc_rsp_type     expected_cells [$];
   int                         errors;

   function new();
      foreach (hist[i]) hist[i] = 1'b0;
      clear_position();
      cols_reg = gnmc_pkg::COL_W'(GRID_MAX_COLS);
      rows_reg = gnmc_pkg::ROW_W'(1);
      errors   = 0;
   endfunction

   function void clear_position();
      in_row  = 0;
      in_col  = 0;
      out_row = 0;
      out_col = 0;
   endfunction

   function int unsigned frame_cols();
      int unsigned c;
      c = cols_reg;
      if (c == 0) c = 1;
      if (c > GRID_MAX_COLS) c = GRID_MAX_COLS;
      return c;
   endfunction

   function int unsigned frame_rows();
      int unsigned r;
      r = rows_reg;
      if (r == 0) r = 1;
      return r;
   endfunction

   function int pending();
      return expected_cells.size();
   endfunction

   function void write_reg(logic [gnmc_pkg::CSR_IDX_W-1:0] idx,
                           logic [gnmc_pkg::CSR_DATA_W-1:0] val);
      case (idx)
         gnmc_pkg::CSR_COLUMNS: begin
            cols_reg = val[gnmc_pkg::COL_W-1:0];
            clear_position();
         end
         gnmc_pkg::CSR_ROWS: begin
            rows_reg = val[gnmc_pkg::ROW_W-1:0];
            clear_position();
         end
         default: ;
      endcase
   endfunction

   // the cell just arriving is not in the history yet
   function bit mine_at(int unsigned q, bit has_new, int unsigned new_q, bit new_v);
      if (has_new && q == new_q) return new_v;
      return hist[q % HIST_DEPTH];
   endfunction

   function void count_cell(int unsigned c, int unsigned r, bit has_new,
                            int unsigned new_q, bit new_v);
      int unsigned            p;
      int                     dr, dc, rr, cc;
      gnmc_pkg::gnmc_rsp_type e;
      p = out_row * c + out_col;
      if (mine_at(p, has_new, new_q, new_v)) begin
         e.cell_code = gnmc_pkg::MINE_CODE;
      end else begin
         e.cell_code = '0;
         for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
               rr = int'(out_row) + dr;
               cc = int'(out_col) + dc;
               if (!(dr == 0 && dc == 0) && rr >= 0 && rr < int'(r) &&
                   cc >= 0 && cc < int'(c))
                  e.cell_code += gnmc_pkg::CODE_W'(mine_at(rr * c + cc, has_new,
                                                           new_q, new_v));
            end
         end
      end
      e.row_end   = (out_col == c - 1);
      e.frame_end = e.row_end && (out_row == r - 1);
      expected_cells.push_back(e);
      if (e.frame_end) begin
         clear_position();
      end else if (e.row_end) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
   endfunction

   function void note_request(gnmc_pkg::gnmc_req_type req);
      int unsigned c, r, in_lin, out_lin;
      c = frame_cols();
      r = frame_rows();
      if (in_row > r || (in_row == r && in_col != 0) || in_col >= c ||
          out_row >= r || out_col >= c)
         clear_position();
      in_lin  = in_row * c + in_col;
      out_lin = out_row * c + out_col;
      if (req.mode == gnmc_pkg::MODE_CELL) begin
         // cells past the end of the frame are dropped
         if (in_row >= r) return;
         in_col++;
         if (in_col == c) begin
            in_col = 0;
            in_row++;
         end
         if (in_lin + 1 >= out_lin + c + 2)
            count_cell(c, r, 1'b1, in_lin, req.is_mine);
         hist[in_lin % HIST_DEPTH] = req.is_mine;
      end else if (in_row >= r && out_lin < in_lin) begin
         count_cell(c, r, 1'b0, 0, 1'b0);
      end
   endfunction

   function void check_result(gnmc_pkg::gnmc_rsp_type act);
      gnmc_pkg::gnmc_rsp_type e;
      if (expected_cells.size() == 0) begin
         $display("%0t: unexpected result, actual code %0d row_end %0b frame_end %0b",
                  $time, act.cell_code, act.row_end, act.frame_end);
         errors++;
         return;
      end
      e = expected_cells.pop_front();
      if (act.cell_code !== e.cell_code) begin
         $display("%0t: cell_code expected %0d actual %0d", $time, e.cell_code, act.cell_code);
         errors++;
      end
      if (act.row_end !== e.row_end) begin
         $display("%0t: row_end expected %0b actual %0b", $time, e.row_end, act.row_end);
         errors++;
      end
      if (act.frame_end !== e.frame_end) begin
         $display("%0t: frame_end expected %0b actual %0b", $time, e.frame_end, act.frame_end);
         errors++;
      end
   endfunction
endclass

module tb_top;

   // indexes with no register behind them; writes there must change nothing
   localparam logic [gnmc_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [gnmc_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;
   localparam int IDLE_LIMIT = 2000;

   logic                            clock;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   gnmc_pkg::gnmc_req_type          req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   gnmc_pkg::gnmc_rsp_type          rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [gnmc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [gnmc_pkg::CSR_DATA_W-1:0] csr_data  = '0;

   mine_count_board board = new();

   // idle knobs, changed per frame; both zero in the closing stretch
   int gap_pct   = 0;
   int stall_pct = 0;
   int frame_no  = 0;

   grid_neighbor_mine_count #(
      .MAX_COLUMNS(GRID_MAX_COLS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Everything the block accepts goes to the scoreboard, sampled at the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.write_reg(csr_index, csr_data);
         if (rsp_valid && !rsp_stall) board.check_result(rsp_data);
         if (req_valid && !req_stall) board.note_request(req_data);
      end
   end

   // Result-side backpressure: random stall bursts of random length.
   initial begin
      forever begin
         @(posedge clock);
         if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: too long without any handshake means the block is stuck.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // One request; a random gap before it, then held until accepted.
   task automatic send_req(input logic mode, input logic mine);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{mode: mode, is_mine: mine};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Hold off requests until every predicted result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // Register write with the block idle. A trailing request may still sit in
   // the window stage with no result due, so give it the pipeline depth too.
   // Returns after the edge that follows the write, so the scoreboard has taken it.
   task automatic write_csr(input logic [gnmc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [gnmc_pkg::CSR_DATA_W-1:0] val);
      drain_results();
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // One frame of cells, cut short at stop_at, then the flush requests that
   // drain it. Noise: stray flushes mid-frame, cells past the end, extra flushes.
   task automatic run_frame(input int unsigned stop_at, input bit noisy);
      int unsigned n_cells, cols, k, mine_pct;
      cols     = board.frame_cols();
      n_cells  = cols * board.frame_rows();
      mine_pct = $urandom_range(0, 100);
      for (k = 0; k < stop_at; k++) begin
         if (noisy && $urandom_range(0, 99) < 5)
            send_req(gnmc_pkg::MODE_FLUSH, 1'($urandom_range(0, 1)));
         // once, hold the sender mid-frame until the results catch up
         if (frame_no == 2 && k == stop_at / 2) drain_results();
         send_req(gnmc_pkg::MODE_CELL, $urandom_range(0, 99) < mine_pct);
      end
      if (stop_at < n_cells) begin
         // broken frame: flushes before the frame is complete do nothing
         if (noisy) repeat ($urandom_range(1, 2)) send_req(gnmc_pkg::MODE_FLUSH, 1'b0);
      end else begin
         if (noisy && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
               send_req(gnmc_pkg::MODE_CELL, 1'($urandom_range(0, 1)));
         repeat (cols + 1 + (noisy ? $urandom_range(0, 2) : 0))
            send_req(gnmc_pkg::MODE_FLUSH, 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin : stimulus
      int unsigned                     counted, n_cells, stop_at, sel;
      logic [gnmc_pkg::CSR_DATA_W-1:0] cols_raw, rows_raw;
      bit                              must_write, extreme, noisy;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed ----
      // Reset sizes are 128 x 1: three cells are far short of a result.
      send_req(gnmc_pkg::MODE_FLUSH, 1'b1);
      send_req(gnmc_pkg::MODE_CELL, 1'b1);
      send_req(gnmc_pkg::MODE_CELL, 1'b0);
      send_req(gnmc_pkg::MODE_CELL, 1'b1);

      // 3 x 2 frame; the write drops the partial default frame.
      write_csr(gnmc_pkg::CSR_COLUMNS, 10'd3);
      write_csr(gnmc_pkg::CSR_ROWS, 10'd2);
      send_req(gnmc_pkg::MODE_FLUSH, 1'b0);      // frame not in yet
      send_req(gnmc_pkg::MODE_CELL, 1'b1);
      send_req(gnmc_pkg::MODE_CELL, 1'b0);
      send_req(gnmc_pkg::MODE_CELL, 1'b0);
      // unmapped indexes in mid-frame: the frame must carry on
      write_csr(CSR_SPARE_2, 10'h3FF);
      write_csr(CSR_SPARE_3, 10'h2AA);
      send_req(gnmc_pkg::MODE_CELL, 1'b0);
      send_req(gnmc_pkg::MODE_CELL, 1'b1);
      send_req(gnmc_pkg::MODE_CELL, 1'b1);
      send_req(gnmc_pkg::MODE_CELL, 1'b1);       // beyond the frame
      repeat (4) send_req(gnmc_pkg::MODE_FLUSH, 1'b1);
      send_req(gnmc_pkg::MODE_FLUSH, 1'b0);      // nothing pending

      // zero columns and zero rows both act as 1: single-cell frames
      write_csr(gnmc_pkg::CSR_COLUMNS, 10'd0);
      write_csr(gnmc_pkg::CSR_ROWS, 10'd0);
      send_req(gnmc_pkg::MODE_CELL, 1'b1);
      send_req(gnmc_pkg::MODE_FLUSH, 1'b0);
      send_req(gnmc_pkg::MODE_CELL, 1'b0);
      send_req(gnmc_pkg::MODE_FLUSH, 1'b1);

      // ---- random frames ----
      counted    = 0;
      must_write = 1'b1;
      cols_raw   = 10'd1;
      rows_raw   = 10'd1;
      while (counted < 1000) begin
         frame_no++;
         extreme = 1'b1;
         if (counted >= 850) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 30);
         end
         case (frame_no)
            3: begin
               cols_raw = 10'h2FF;   // low byte 255, capped at the buffer width
               rows_raw = 10'd2;
            end
            6: begin
               cols_raw = 10'd128;   // full-width single row
               rows_raw = 10'd1;
            end
            default: begin
               extreme = 1'b0;
               sel = $urandom_range(0, 19);
               if (!must_write && sel >= 17) begin
                  // same sizes again: the frame restarts on its own
               end else if (sel == 0) begin
                  cols_raw = 10'd0;
                  rows_raw = 10'($urandom_range(0, 6));
               end else if (sel == 1) begin
                  // wide rows, upper data bits ignored by the column register
                  cols_raw = 10'($urandom_range(0, 1023));
                  rows_raw = 10'($urandom_range(0, 1));
               end else begin
                  cols_raw = 10'($urandom_range(1, 8));
                  rows_raw = 10'($urandom_range(1, 8));
               end
               if (!must_write && sel >= 17) must_write = 1'b0;
               else                          must_write = 1'b1;
            end
         endcase
         if (extreme || must_write) begin
            if ($urandom_range(0, 1) == 0) begin
               write_csr(gnmc_pkg::CSR_COLUMNS, cols_raw);
               write_csr(gnmc_pkg::CSR_ROWS, rows_raw);
            end else begin
               write_csr(gnmc_pkg::CSR_ROWS, rows_raw);
               write_csr(gnmc_pkg::CSR_COLUMNS, cols_raw);
            end
         end

         n_cells    = board.frame_cols() * board.frame_rows();
         stop_at    = n_cells;
         noisy      = !extreme && ($urandom_range(0, 3) != 0);
         must_write = 1'b0;
         if (!extreme && $urandom_range(0, 24) == 0) begin
            // abandon the frame; the next write drops what is pending
            stop_at    = $urandom_range(0, n_cells - 1);
            must_write = 1'b1;
         end
         run_frame(stop_at, noisy);
         counted += stop_at + ((stop_at == n_cells) ? board.frame_cols() + 1 : 0);
      end

      // ---- wind down ----
      drain_results();
      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
